@@ rtl/wmme_pkg.sv @@
// ----------------------------------------------------------------------------
// wmme_pkg
// Shared types and constants of the weight matrix multiply-accumulate engine.
// ----------------------------------------------------------------------------
package wmme_pkg;

  localparam int unsigned CmdBits   = 3;
  localparam int unsigned IdxBits   = 4;
  localparam int unsigned DataBits  = 16;
  localparam int unsigned SizeBits  = 5;
  localparam int unsigned RateBits  = 16;
  localparam int unsigned MaxResult = 16;

  typedef enum logic [CmdBits-1:0] {
    CMD_WR_WEIGHT = 3'd0,
    CMD_WR_ROW    = 3'd1,
    CMD_WR_COL    = 3'd2,
    CMD_MV        = 3'd3,
    CMD_VM        = 3'd4,
    CMD_DELTA     = 3'd5,
    CMD_RD_WEIGHT = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_RATE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_VEC_LOAD,
    ST_MAC,
    ST_FINISH,
    ST_DELTA
  } state_e;

  // One classified command, as it travels through the queue.
  typedef struct packed {
    cmd_e                cmd;
    logic [IdxBits-1:0]  row;
    logic [IdxBits-1:0]  col;
    logic [DataBits-1:0] data;
  } item_t;

  typedef struct packed {
    logic                push_ok;
    logic                empty;
  } qstat_t;

endpackage

@@ rtl/wmme_front.sv @@
// ----------------------------------------------------------------------------
// wmme_front
// Accepts commands, drops unknown ones and queues the rest for the back end.
// ----------------------------------------------------------------------------
module wmme_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  wmme_pkg::item_t      item_i,
  input  logic                 pop_i,
  output wmme_pkg::item_t      item_o,
  output wmme_pkg::qstat_t     stat_o
);

  localparam int unsigned Depth = 2;

  wmme_pkg::item_t mem_q [Depth];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push;

  assign stat_o.push_ok = (cnt_q != 2'd2);
  assign stat_o.empty   = (cnt_q == 2'd0);
  assign push   = start_i && stat_o.push_ok && (item_i.cmd != wmme_pkg::CMD_NONE);
  assign item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

@@ rtl/wmme_back.sv @@
// ----------------------------------------------------------------------------
// wmme_back
// Executes queued commands against the weight memory and the two vectors.
// ----------------------------------------------------------------------------
module wmme_back #(
  parameter int unsigned MaxRows = 16,
  parameter int unsigned MaxCols = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wmme_pkg::item_t                 item_i,
  input  wmme_pkg::qstat_t                stat_i,
  output logic                            pop_o,
  input  logic [wmme_pkg::SizeBits-1:0]   rows_i,
  input  logic [wmme_pkg::SizeBits-1:0]   cols_i,
  input  logic [wmme_pkg::RateBits-1:0]   rate_i,
  output logic                            res_valid_o,
  output logic                            res_kind_o,
  output logic [wmme_pkg::IdxBits-1:0]    res_index_o,
  output logic signed [wmme_pkg::DataBits-1:0] res_value_o,
  output logic                            res_last_o
);

  localparam int unsigned RowBits = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColBits = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned WBits   = RowBits + ColBits;
  localparam int unsigned WDepth  = 1 << WBits;
  localparam int unsigned DB      = wmme_pkg::DataBits;
  localparam int unsigned Frac    = DB - 4;
  localparam int unsigned AccBits = 2 * DB + 8;
  localparam int unsigned RateBitsX = wmme_pkg::RateBits + 2;
  localparam int unsigned RLim    = (MaxRows < wmme_pkg::MaxResult) ? MaxRows
                                                                    : wmme_pkg::MaxResult;
  localparam int unsigned CLim    = (MaxCols < wmme_pkg::MaxResult) ? MaxCols
                                                                    : wmme_pkg::MaxResult;
  localparam logic signed [AccBits-1:0] SatHi = AccBits'((1 << (DB - 1)) - 1);
  localparam logic signed [AccBits-1:0] SatLo = -AccBits'(1 << (DB - 1));

  logic signed [DB-1:0] weight_mem [WDepth];
  logic signed [DB-1:0] row_q [MaxRows];
  logic signed [DB-1:0] col_q [MaxCols];

  wmme_pkg::state_e state_q, state_d;
  wmme_pkg::item_t  cur_q;
  logic [4:0]       outer_q, inner_q;
  logic [4:0]       nr, nc, n_outer, n_inner;
  logic signed [AccBits-1:0] acc_q;
  logic signed [DB-1:0]      wrd_q;
  logic                      wrd_v_q;
  logic signed [DB-1:0]      vec_a_q;
  logic signed [2*DB-1:0]    prod_q;
  logic                      prod_v_q;
  logic                      r_ok, c_ok;

  function automatic logic signed [DB-1:0] sat(input logic signed [AccBits-1:0] v);
    if (v > SatHi) return SatHi[DB-1:0];
    if (v < SatLo) return SatLo[DB-1:0];
    return v[DB-1:0];
  endfunction

  function automatic logic [4:0] clamp(input logic [4:0] v, input int unsigned lim);
    if (v == 5'd0) return 5'd1;
    if (32'(v) > lim) return 5'(lim);
    return v;
  endfunction

  assign nr = clamp(rows_i, RLim);
  assign nc = clamp(cols_i, CLim);
  assign r_ok = 32'(cur_q.row) < MaxRows;
  assign c_ok = 32'(cur_q.col) < MaxCols;
  assign n_outer = (cur_q.cmd == wmme_pkg::CMD_VM) ? nc : nr;
  assign n_inner = (cur_q.cmd == wmme_pkg::CMD_VM) ? nr : nc;

  // Row/column for the element at (outer, inner) of the current command.
  logic [RowBits-1:0] m_row;
  logic [ColBits-1:0] m_col;
  logic [RowBits-1:0] d_row;
  logic [ColBits-1:0] d_col;
  logic               in_done;
  logic signed [DB-1:0]   vec_b;
  logic signed [DB-1:0]   old_v;
  logic signed [AccBits-1:0] rnd;
  logic signed [DB-1:0]   new_v;
  // Delta pipeline.
  logic               dl_issue;
  logic               dl_v1_q, dl_v2_q, dl_v3_q;
  logic [WBits-1:0]   dl_a1_q, dl_a2_q, dl_a3_q;
  logic signed [2*DB-1:0] dl_p_q;
  logic signed [DB+8:0]   dl_q_q;
  logic signed [DB+RateBitsX-1:0] dl_t_q;
  logic signed [AccBits-1:0] dl_sum;

  always_comb begin
    if (cur_q.cmd == wmme_pkg::CMD_VM) begin
      m_row = RowBits'(inner_q);
      m_col = ColBits'(outer_q);
      vec_b = row_q[RowBits'(inner_q)];
      old_v = col_q[ColBits'(outer_q)];
    end else begin
      m_row = RowBits'(outer_q);
      m_col = ColBits'(inner_q);
      vec_b = col_q[ColBits'(inner_q)];
      old_v = row_q[RowBits'(outer_q)];
    end
    d_row = RowBits'(outer_q);
    d_col = ColBits'(inner_q);
  end

  assign in_done = (inner_q == n_inner);
  assign rnd = (acc_q + AccBits'(1 << (Frac - 1))) >>> Frac;
  assign new_v = sat(rnd);
  assign dl_sum = AccBits'(wrd_q) + AccBits'(dl_t_q);
  assign dl_issue = (state_q == wmme_pkg::ST_DELTA) && (outer_q != nr);

  logic [WBits-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;
  logic [WBits-1:0] wr_addr;
  logic signed [DB-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) weight_mem[wr_addr] <= wr_data;
    if (rd_en) wrd_q <= weight_mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = {m_row, m_col};
    wr_en       = 1'b0;
    wr_addr     = {RowBits'(cur_q.row), ColBits'(cur_q.col)};
    wr_data     = cur_q.data;
    res_valid_o = 1'b0;
    res_kind_o  = 1'b0;
    res_index_o = '0;
    res_value_o = '0;
    res_last_o  = 1'b1;
    unique case (state_q)
      wmme_pkg::ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = wmme_pkg::ST_SIMPLE;
        end
      end
      wmme_pkg::ST_SIMPLE: begin
        rd_addr = {RowBits'(cur_q.row), ColBits'(cur_q.col)};
        unique case (cur_q.cmd)
          wmme_pkg::CMD_WR_WEIGHT: begin
            wr_en       = r_ok && c_ok;
            res_valid_o = 1'b1;
            res_index_o = cur_q.row;
            res_value_o = (r_ok && c_ok) ? cur_q.data : '0;
            state_d     = wmme_pkg::ST_IDLE;
          end
          wmme_pkg::CMD_WR_ROW: begin
            res_valid_o = 1'b1;
            res_index_o = cur_q.row;
            res_value_o = r_ok ? cur_q.data : '0;
            state_d     = wmme_pkg::ST_IDLE;
          end
          wmme_pkg::CMD_WR_COL: begin
            res_valid_o = 1'b1;
            res_index_o = cur_q.col;
            res_value_o = c_ok ? cur_q.data : '0;
            state_d     = wmme_pkg::ST_IDLE;
          end
          wmme_pkg::CMD_RD_WEIGHT: begin
            rd_en   = 1'b1;
            state_d = wmme_pkg::ST_FINISH;
          end
          wmme_pkg::CMD_DELTA: state_d = wmme_pkg::ST_DELTA;
          default:             state_d = wmme_pkg::ST_VEC_LOAD;
        endcase
      end
      wmme_pkg::ST_VEC_LOAD: begin
        rd_en   = 1'b1;
        state_d = wmme_pkg::ST_MAC;
      end
      wmme_pkg::ST_MAC: begin
        rd_en = !in_done;
        if (in_done && !wrd_v_q && !prod_v_q) begin
          res_valid_o = 1'b1;
          res_kind_o  = 1'b1;
          res_index_o = 4'(outer_q);
          res_value_o = new_v;
          res_last_o  = (outer_q + 5'd1 == n_outer);
          state_d     = res_last_o ? wmme_pkg::ST_IDLE : wmme_pkg::ST_VEC_LOAD;
        end
      end
      wmme_pkg::ST_FINISH: begin
        res_valid_o = 1'b1;
        res_kind_o  = 1'b1;
        res_index_o = cur_q.col;
        res_value_o = (r_ok && c_ok) ? wrd_q : '0;
        state_d     = wmme_pkg::ST_IDLE;
      end
      wmme_pkg::ST_DELTA: begin
        rd_en   = dl_v2_q;
        rd_addr = dl_a2_q;
        wr_en   = dl_v3_q;
        wr_addr = dl_a3_q;
        wr_data = sat(dl_sum);
        if (outer_q == nr && !dl_v1_q && !dl_v2_q && !dl_v3_q) begin
          res_valid_o = 1'b1;
          state_d     = wmme_pkg::ST_IDLE;
        end
      end
      default: state_d = wmme_pkg::ST_IDLE;
    endcase
  end

  // In the delta rule the weight is read from the address in dl_a2_q, so wrd_q
  // holds it in the cycle the scaled term in dl_t_q is ready.
  always_ff @(posedge clk_i) begin
    if (state_q == wmme_pkg::ST_IDLE && pop_o) cur_q <= item_i;
    if (state_q == wmme_pkg::ST_SIMPLE) begin
      if (cur_q.cmd == wmme_pkg::CMD_WR_ROW && r_ok) row_q[RowBits'(cur_q.row)] <= cur_q.data;
      if (cur_q.cmd == wmme_pkg::CMD_WR_COL && c_ok) col_q[ColBits'(cur_q.col)] <= cur_q.data;
    end
    if (state_q == wmme_pkg::ST_VEC_LOAD) begin
      acc_q <= AccBits'(old_v) <<< Frac;
    end
    vec_a_q <= vec_b;
    prod_q  <= wrd_q * vec_a_q;
    if (state_q == wmme_pkg::ST_MAC && prod_v_q) acc_q <= acc_q + AccBits'(prod_q);
    if (state_q == wmme_pkg::ST_MAC && res_valid_o) begin
      if (cur_q.cmd == wmme_pkg::CMD_VM) col_q[ColBits'(outer_q)] <= new_v;
      else row_q[RowBits'(outer_q)] <= new_v;
    end
    dl_a1_q <= {d_row, d_col};
    dl_a2_q <= dl_a1_q;
    dl_a3_q <= dl_a2_q;
    dl_p_q  <= row_q[d_row] * col_q[d_col];
    dl_q_q  <= (DB+9)'((dl_p_q + (2*DB)'(1 << (Frac - 1))) >>> Frac);
    dl_t_q  <= (DB+RateBitsX)'(((DB+RateBitsX+1)'(dl_q_q) * $signed({1'b0, rate_i})
                + (DB+RateBitsX+1)'(1 << 15)) >>> 16);
  end

  // Control state, loop counters and pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wmme_pkg::ST_IDLE;
      outer_q  <= '0;
      inner_q  <= '0;
      wrd_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      dl_v1_q  <= 1'b0;
      dl_v2_q  <= 1'b0;
      dl_v3_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      wrd_v_q  <= ((state_q == wmme_pkg::ST_MAC) || (state_q == wmme_pkg::ST_VEC_LOAD))
                  && rd_en;
      prod_v_q <= wrd_v_q;
      dl_v1_q  <= dl_issue;
      dl_v2_q  <= dl_v1_q;
      dl_v3_q  <= dl_v2_q;
      unique case (state_q)
        wmme_pkg::ST_SIMPLE: begin
          outer_q <= '0;
          inner_q <= '0;
        end
        wmme_pkg::ST_VEC_LOAD: inner_q <= 5'd1;
        wmme_pkg::ST_MAC: begin
          if (!in_done) begin
            inner_q <= inner_q + 5'd1;
          end else if (res_valid_o) begin
            inner_q <= '0;
          end
          if (res_valid_o) outer_q <= outer_q + 5'd1;
        end
        wmme_pkg::ST_DELTA: begin
          if (outer_q != nr) begin
            if (inner_q + 5'd1 == nc) begin
              inner_q <= '0;
              outer_q <= outer_q + 5'd1;
            end else begin
              inner_q <= inner_q + 5'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/weight_matrix_mac_engine.sv @@
// ----------------------------------------------------------------------------
// weight_matrix_mac_engine
// Weight matrix with row and column vectors: writes, reads, M*x, x*M, delta rule.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-entry
// queue lets a new command be taken while the back end works. Results appear
// for one cycle each with result_valid_o; the receiver cannot stall them.
// The back end fetches every command in ST_IDLE and decodes it in ST_SIMPLE.
// Writes finish there and weight reads go on through ST_FINISH. M*x and x*M
// then step through ST_VEC_LOAD and ST_MAC for each emitted element, limited
// by the single weight memory read port and one multiply-accumulate unit.
// The delta rule then runs in ST_DELTA, one weight read and write per cycle,
// plus the drain of its pipeline.
// ----------------------------------------------------------------------------
module weight_matrix_mac_engine #(
  parameter int unsigned MAX_ROWS   = 16,
  parameter int unsigned MAX_COLS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  row_index_i,
  input  logic [3:0]  col_index_i,
  input  logic signed [15:0] data_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic        kind_o,
  output logic [3:0]  out_index_o,
  output logic signed [15:0] out_value_o,
  output logic        last_o
);

  wmme_pkg::item_t  in_item, q_item;
  wmme_pkg::qstat_t qstat;
  logic             pop;
  logic [4:0]       rows_q, cols_q;
  logic [15:0]      rate_q;

  assign in_item.cmd  = wmme_pkg::cmd_e'(cmd_i);
  assign in_item.row  = row_index_i;
  assign in_item.col  = col_index_i;
  assign in_item.data = data_value_i;
  assign busy         = !qstat.push_ok;
  assign cfg_ready_o  = 1'b1;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd16;
      cols_q <= 5'd16;
      rate_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wmme_pkg::CFG_ROWS: rows_q <= cfg_data_i[4:0];
        wmme_pkg::CFG_COLS: cols_q <= cfg_data_i[4:0];
        wmme_pkg::CFG_RATE: rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wmme_front u_front (
    .clk_i, .rst_ni,
    .start_i (start),
    .item_i  (in_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .stat_o  (qstat)
  );

  wmme_back #(.MaxRows(MAX_ROWS), .MaxCols(MAX_COLS)) u_back (
    .clk_i, .rst_ni,
    .item_i      (q_item),
    .stat_i      (qstat),
    .pop_o       (pop),
    .rows_i      (rows_q),
    .cols_i      (cols_q),
    .rate_i      (rate_q),
    .res_valid_o (result_valid_o),
    .res_kind_o  (kind_o),
    .res_index_o (out_index_o),
    .res_value_o (out_value_o),
    .res_last_o  (last_o)
  );

endmodule

@@ rtl/wmme_checker.sv @@
// ----------------------------------------------------------------------------
// wmme_checker
// Port-level checks of the engine.
// ----------------------------------------------------------------------------
module wmme_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic result_valid_o,
  input logic kind_o,
  input logic last_o
);

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !kind_o |-> last_o) else $error("ack without last");
  a_busy_no_result_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !result_valid_o) else $error("result in reset");
  a_busy_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !busy) else $error("busy in reset");

endmodule

bind weight_matrix_mac_engine wmme_checker u_wmme_checker (
  .clk_i, .rst_ni, .busy, .result_valid_o, .kind_o, .last_o
);

@@ verif/weight_matrix_mac_engine_tb.sv @@
// ----------------------------------------------------------------------------
// weight_matrix_mac_engine_tb
// Self-checking bench for the weight matrix multiply-accumulate engine.
// ----------------------------------------------------------------------------
// Commands are driven over the start/busy handshake. The bench starts with a
// short directed set of extremes, then runs random traffic across several
// size and rate settings. A scoreboard mirrors the matrix, the two vectors
// and the registers. It works out the results of every accepted command and
// checks each strobed result, in order, against the oldest expectation.
// Commands that would read a never-written entry become writes of that entry.
// ----------------------------------------------------------------------------
module weight_matrix_mac_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [3:0]  index;
    logic [15:0] value;
    logic        last;
  } mac_result_t;

  class mac_scoreboard;
    longint      weight_mem [16][16];
    longint      row_vec [16];
    longint      col_vec [16];
    bit          weight_set [16][16];
    bit          row_set [16];
    bit          col_set [16];
    int unsigned rows_reg = 16;
    int unsigned cols_reg = 16;
    longint      rate_reg = 0;
    mac_result_t expected_results [$];
    int          mismatches = 0;

    function int unsigned clamp_size(int unsigned v);
      if (v < 1) return 1;
      if (v > 16) return 16;
      return v;
    endfunction

    // Round half up to n fewer fraction bits; >>> floors a signed value.
    function longint round_down(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint saturate(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void set_reg(wmme_pkg::cfg_idx_e idx, logic [15:0] data);
      case (idx)
        wmme_pkg::CFG_ROWS: rows_reg = 32'(data[4:0]);
        wmme_pkg::CFG_COLS: cols_reg = 32'(data[4:0]);
        wmme_pkg::CFG_RATE: rate_reg = 64'(data);
        default: ;
      endcase
    endfunction

    function void push(logic kind, logic [3:0] index, longint value, logic last);
      mac_result_t e;
      e.kind  = kind;
      e.index = index;
      e.value = value[15:0];
      e.last  = last;
      expected_results.push_back(e);
    endfunction

    // A matrix command reads every entry inside the sizes in use. If one was
    // never written, the command turns into a write of that entry.
    function void make_legal(inout wmme_pkg::cmd_e cmd, inout logic [3:0] r,
                             inout logic [3:0] c);
      int unsigned nr;
      int unsigned nc;
      nr = clamp_size(rows_reg);
      nc = clamp_size(cols_reg);
      if (cmd == wmme_pkg::CMD_RD_WEIGHT && !weight_set[r][c]) begin
        cmd = wmme_pkg::CMD_WR_WEIGHT;
      end else if (cmd inside {wmme_pkg::CMD_MV, wmme_pkg::CMD_VM,
                               wmme_pkg::CMD_DELTA}) begin
        for (int j = 0; j < nr; j++) begin
          if (!row_set[j]) begin
            cmd = wmme_pkg::CMD_WR_ROW;
            r = 4'(j);
            return;
          end
        end
        for (int i = 0; i < nc; i++) begin
          if (!col_set[i]) begin
            cmd = wmme_pkg::CMD_WR_COL;
            c = 4'(i);
            return;
          end
        end
        for (int j = 0; j < nr; j++) begin
          for (int i = 0; i < nc; i++) begin
            if (!weight_set[j][i]) begin
              cmd = wmme_pkg::CMD_WR_WEIGHT;
              r = 4'(j);
              c = 4'(i);
              return;
            end
          end
        end
      end
    endfunction

    function void note_command(wmme_pkg::cmd_e cmd, logic [3:0] r, logic [3:0] c,
                               logic signed [15:0] d);
      int unsigned nr;
      int unsigned nc;
      longint acc;
      longint q;
      nr = clamp_size(rows_reg);
      nc = clamp_size(cols_reg);
      case (cmd)
        wmme_pkg::CMD_WR_WEIGHT: begin
          weight_mem[r][c] = d;
          weight_set[r][c] = 1'b1;
          push(1'b0, r, d, 1'b1);
        end
        wmme_pkg::CMD_WR_ROW: begin
          row_vec[r] = d;
          row_set[r] = 1'b1;
          push(1'b0, r, d, 1'b1);
        end
        wmme_pkg::CMD_WR_COL: begin
          col_vec[c] = d;
          col_set[c] = 1'b1;
          push(1'b0, c, d, 1'b1);
        end
        wmme_pkg::CMD_MV: begin
          for (int j = 0; j < nr; j++) begin
            acc = row_vec[j] <<< 12;
            for (int i = 0; i < nc; i++) acc += weight_mem[j][i] * col_vec[i];
            row_vec[j] = saturate(round_down(acc, 12));
            push(1'b1, 4'(j), row_vec[j], j + 1 == nr);
          end
        end
        wmme_pkg::CMD_VM: begin
          for (int i = 0; i < nc; i++) begin
            acc = col_vec[i] <<< 12;
            for (int j = 0; j < nr; j++) acc += row_vec[j] * weight_mem[j][i];
            col_vec[i] = saturate(round_down(acc, 12));
            push(1'b1, 4'(i), col_vec[i], i + 1 == nc);
          end
        end
        wmme_pkg::CMD_DELTA: begin
          // The product is rounded to the value format before the rate.
          for (int j = 0; j < nr; j++) begin
            for (int i = 0; i < nc; i++) begin
              q = round_down(row_vec[j] * col_vec[i], 12);
              weight_mem[j][i] = saturate(weight_mem[j][i] + round_down(q * rate_reg, 16));
            end
          end
          push(1'b0, 4'd0, 64'sd0, 1'b1);
        end
        wmme_pkg::CMD_RD_WEIGHT: push(1'b1, c, weight_mem[r][c], 1'b1);
        default: ;
      endcase
    endfunction

    function void check_result(logic kind, logic [3:0] index, logic [15:0] value,
                               logic last);
      mac_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0b index=%0d value=%h last=%0b",
                   $realtime, kind, index, value, last);
        return;
      end
      e = expected_results.pop_front();
      if (kind !== e.kind || index !== e.index || value !== e.value || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected kind=%0b index=%0d value=%h last=%0b, got %0b %0d %h %0b",
                   $realtime, e.kind, e.index, e.value, e.last, kind, index, value, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd_i = '0;
  logic [3:0]  row_index_i = '0;
  logic [3:0]  col_index_i = '0;
  logic signed [15:0] data_value_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic        kind_o;
  logic [3:0]  out_index_o;
  logic signed [15:0] out_value_o;
  logic        last_o;

  mac_scoreboard mac_model = new();
  int unsigned   sender_idle_pct = 0;

  weight_matrix_mac_engine i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The receiver cannot hold results off, so every strobe is a transfer.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      mac_model.check_result(kind_o, out_index_o, out_value_o, last_o);
  end

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic issue_command(wmme_pkg::cmd_e cmd, logic [3:0] r, logic [3:0] c,
                               logic signed [15:0] d);
    mac_model.make_legal(cmd, r, c);
    if ($urandom_range(99) < sender_idle_pct) repeat ($urandom_range(1, 8)) @(negedge clk_i);
    start        = 1'b1;
    cmd_i        = cmd;
    row_index_i  = r;
    col_index_i  = c;
    data_value_i = d;
    do @(posedge clk_i); while (busy);
    mac_model.note_command(cmd, r, c, d);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Waits until every expected result has come, then lets the block settle;
  // unknown commands are dropped at the front and give no result.
  task automatic drain_results();
    while (mac_model.expected_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_register(wmme_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    mac_model.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic wmme_pkg::cmd_e pick_command();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) return wmme_pkg::CMD_WR_WEIGHT;
    if (p < 40) return wmme_pkg::CMD_WR_ROW;
    if (p < 50) return wmme_pkg::CMD_WR_COL;
    if (p < 65) return wmme_pkg::CMD_MV;
    if (p < 80) return wmme_pkg::CMD_VM;
    if (p < 88) return wmme_pkg::CMD_DELTA;
    if (p < 98) return wmme_pkg::CMD_RD_WEIGHT;
    return wmme_pkg::CMD_NONE;
  endfunction

  initial begin
    int unsigned phase_rows [6] = '{5, 0, 16, 31, 7, 1};
    int unsigned phase_cols [6] = '{3, 0, 16, 31, 1, 9};
    int unsigned phase_rate [6] = '{65535, 0, 300, 65535, 4096, 1234};
    int unsigned phase_idle [6] = '{0, 71, 0, 33, 71, 0};

    #1 rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed extremes on a two by two matrix, plus the far corner entries.
    write_register(wmme_pkg::CFG_ROWS, 16'd2);
    write_register(wmme_pkg::CFG_COLS, 16'd2);
    write_register(wmme_pkg::CFG_RATE, 16'hffff);
    issue_command(wmme_pkg::CMD_WR_WEIGHT, 4'd0, 4'd0, 16'sh7fff);
    issue_command(wmme_pkg::CMD_WR_WEIGHT, 4'd0, 4'd1, 16'sh8000);
    issue_command(wmme_pkg::CMD_WR_WEIGHT, 4'd1, 4'd0, -16'sd1);
    issue_command(wmme_pkg::CMD_WR_WEIGHT, 4'd1, 4'd1, 16'sh1000);
    issue_command(wmme_pkg::CMD_WR_WEIGHT, 4'd15, 4'd15, 16'sh5a5a);
    issue_command(wmme_pkg::CMD_WR_ROW, 4'd0, 4'd0, 16'sh7fff);
    issue_command(wmme_pkg::CMD_WR_ROW, 4'd1, 4'd0, 16'sh8000);
    issue_command(wmme_pkg::CMD_WR_ROW, 4'd15, 4'd0, 16'sh0001);
    issue_command(wmme_pkg::CMD_WR_COL, 4'd0, 4'd0, 16'sh7fff);
    issue_command(wmme_pkg::CMD_WR_COL, 4'd0, 4'd1, 16'sh8000);
    issue_command(wmme_pkg::CMD_WR_COL, 4'd0, 4'd15, -16'sd2);
    issue_command(wmme_pkg::CMD_MV, 4'd0, 4'd0, 16'sd0);
    issue_command(wmme_pkg::CMD_VM, 4'd0, 4'd0, 16'sd0);
    issue_command(wmme_pkg::CMD_DELTA, 4'd0, 4'd0, 16'sd0);
    issue_command(wmme_pkg::CMD_RD_WEIGHT, 4'd0, 4'd1, 16'sd0);
    issue_command(wmme_pkg::CMD_RD_WEIGHT, 4'd15, 4'd15, 16'sd0);
    issue_command(wmme_pkg::CMD_NONE, 4'd15, 4'd15, 16'shffff);
    issue_command(wmme_pkg::CMD_MV, 4'd0, 4'd0, 16'sd0);

    // Random traffic, one phase per register setting. A size of zero acts as
    // one and a size past the store is clamped, so both appear here.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      write_register(wmme_pkg::CFG_ROWS, 16'(phase_rows[ph]));
      write_register(wmme_pkg::CFG_COLS, 16'(phase_cols[ph]));
      write_register(wmme_pkg::CFG_RATE, 16'(phase_rate[ph]));
      sender_idle_pct = phase_idle[ph];
      for (int n = 0; n < 74; n++) begin
        // The sender pauses once mid-phase until every result is back.
        if (n == 37 && ph == 2) drain_results();
        issue_command(pick_command(), 4'($urandom), 4'($urandom), pick_value());
      end
    end

    while (mac_model.expected_results.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mac_model.mismatches == 0 && mac_model.expected_results.size() == 0) begin
      $display("weight_matrix_mac_engine: match");
    end else begin
      $display("weight_matrix_mac_engine: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #30ms;
    $display("weight_matrix_mac_engine: mismatch");
    $finish;
  end

endmodule
